// ===== rtl/intel_hex_record_parser_top_assert.svh =====
// assertion helpers for the hex record parser
`ifndef INTEL_HEX_RECORD_PARSER_TOP_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define IHEX_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ihex assertion failed");

// next-cycle implication
`define IHEX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ihex assertion failed");

`endif

// ===== rtl/ihex_pkg.sv =====
package ihex_pkg;

	localparam logic [1:0] KIND_COUNT = 2'd0;
	localparam logic [1:0] KIND_ADDR  = 2'd1;
	localparam logic [1:0] KIND_WORD  = 2'd2;

	localparam logic [7:0] COLON_CHAR   = 8'h3A;
	localparam logic [9:0] POS_MAX      = 10'd1023;
	localparam logic [9:0] HEADER_CHARS = 10'd9;

	typedef struct packed {
		logic [1:0]  entry_kind;
		logic [15:0] entry_value;
		logic [4:0]  slot;
		logic [15:0] words_total;
	} entry_t;

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
		end
		return t[3:0];
	endfunction

endpackage

// ===== rtl/ihex_char_if.sv =====
interface ihex_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ascii_char;

	modport source (output valid, output ascii_char, input ready);
	modport sink (input valid, input ascii_char, output ready);
endinterface

// ===== rtl/ihex_entry_if.sv =====
interface ihex_entry_if;
	logic        valid;
	logic        ready;
	logic [1:0]  entry_kind;
	logic [15:0] entry_value;
	logic [4:0]  slot;
	logic [15:0] words_total;

	modport source (output valid, output entry_kind, output entry_value, output slot,
		output words_total, input ready);
	modport sink (input valid, input entry_kind, input entry_value, input slot,
		input words_total, output ready);
endinterface

// ===== rtl/ihex_track.sv =====
`include "intel_hex_record_parser_top_assert.svh"

module ihex_track #(
	parameter int RING_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           in_char,
	output logic                 in_ready,
	input  logic                 can_take,
	output logic                 res_valid,
	output ihex_pkg::entry_t     res
);

	localparam int RIDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [RIDX_W-1:0] RIDX_LAST = RIDX_W'(RING_DEPTH - 1);

	logic              valid_s1;
	logic [7:0]        char_s1;

	logic [9:0]        pos_q;
	logic [9:0]        rec_q;
	logic [15:0]       low_q;
	logic [7:0]        high_q;
	logic [RIDX_W-1:0] ring_q;
	logic [15:0]       wc_q;

	logic              colon;
	logic [3:0]        d;
	logic [9:0]        p;
	logic [9:0]        pos_d;
	logic [9:0]        rec_d;
	logic [15:0]       low_d;
	logic [15:0]       sum16;
	logic [7:0]        high_d;
	logic [RIDX_W-1:0] ring_d;
	logic [15:0]       wc_d;
	logic              emit;
	logic [1:0]        kind;
	logic              go;

	always_comb begin
		colon  = (char_s1 == ihex_pkg::COLON_CHAR);
		d      = ihex_pkg::nibble_of(char_s1);
		p      = colon ? 10'd0 : pos_q;
		rec_d  = rec_q;
		low_d  = low_q;
		high_d = high_q;
		wc_d   = wc_q;
		emit   = 1'b0;
		kind   = ihex_pkg::KIND_COUNT;
		sum16  = low_q + {12'h000, d};

		// header fields
		case (p)
			10'd1: begin
				low_d = {8'h00, d, 4'h0};
			end
			10'd2: begin
				low_d = sum16;
				rec_d = {sum16[8:0], 1'b0} + ihex_pkg::HEADER_CHARS;
				emit  = 1'b1;
				kind  = ihex_pkg::KIND_COUNT;
			end
			10'd3: begin
				low_d = {8'h00, d, 4'h0};
			end
			10'd4: begin
				low_d = {sum16[7:0], 8'h00};
			end
			10'd5: begin
				low_d = low_q + {8'h00, d, 4'h0};
			end
			10'd6: begin
				low_d = sum16;
				emit  = 1'b1;
				kind  = ihex_pkg::KIND_ADDR;
			end
			default: begin
			end
		endcase

		// data field, low byte first
		if (p > 10'd8 && p < rec_q) begin
			case (p[1:0])
				2'd1: begin
					low_d = {8'h00, d, 4'h0};
				end
				2'd2: begin
					low_d = sum16;
				end
				2'd3: begin
					high_d = {d, 4'h0};
				end
				default: begin
					high_d = high_q + {4'h0, d};
					low_d  = low_q + {high_d, 8'h00};
					wc_d   = wc_q + 16'd1;
					emit   = 1'b1;
					kind   = ihex_pkg::KIND_WORD;
				end
			endcase
		end

		pos_d  = (p < ihex_pkg::POS_MAX) ? p + 10'd1 : p;
		ring_d = emit ? ((ring_q == RIDX_LAST) ? '0 : ring_q + 1'b1) : ring_q;

		res.entry_kind  = kind;
		res.entry_value = low_d;
		res.slot        = 5'(ring_q);
		res.words_total = wc_d;
		res_valid       = valid_s1 && emit;
		go              = valid_s1 && (!emit || can_take);
		in_ready        = !valid_s1 || go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= in_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			rec_q  <= '0;
			low_q  <= '0;
			high_q <= '0;
			ring_q <= '0;
			wc_q   <= '0;
		end else if (go) begin
			pos_q  <= pos_d;
			rec_q  <= rec_d;
			low_q  <= low_d;
			high_q <= high_d;
			ring_q <= ring_d;
			wc_q   <= wc_d;
		end
	end

	`IHEX_ASSERT_IMPLY(a_colon_silent, clk, arst_n, valid_s1 && colon, !res_valid)
	`IHEX_ASSERT_NEXT(a_word_counted, clk, arst_n, go && emit && kind == ihex_pkg::KIND_WORD, wc_q == $past(wc_q) + 16'd1)
	`IHEX_ASSERT_NEXT(a_ring_moves, clk, arst_n, go && emit, ring_q != $past(ring_q))
	`IHEX_ASSERT_IMPLY(a_ring_range, clk, arst_n, 1'b1, ring_q <= RIDX_LAST)

endmodule

// ===== rtl/ihex_obuf.sv =====
`include "intel_hex_record_parser_top_assert.svh"

module ihex_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  ihex_pkg::entry_t res,
	output logic             can_take,
	output logic             out_valid,
	input  logic             out_ready,
	output ihex_pkg::entry_t out_data
);

	logic             valid_q;
	ihex_pkg::entry_t data_q;

	assign can_take  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && res_valid) begin
			data_q <= res;
		end
	end

	`IHEX_ASSERT_NEXT(a_load_shows, clk, arst_n, can_take && res_valid, valid_q)
	`IHEX_ASSERT_NEXT(a_drain_empty, clk, arst_n, valid_q && out_ready && !res_valid, !valid_q)
	`IHEX_ASSERT_IMPLY(a_kind_legal, clk, arst_n, valid_q, data_q.entry_kind <= ihex_pkg::KIND_WORD)

endmodule

// ===== rtl/intel_hex_record_parser_top.sv =====
// Intel HEX record parser. Takes one ASCII character per item on chars and gives at most
// one entry per character on entries: the byte count (kind 0) after the second character
// of a record, the load address (kind 1) after the sixth, and each 16-bit data word
// (kind 2, low byte first) as its fourth digit arrives, with the ring slot it goes to and
// the running word total. A colon restarts a record; characters other than 0-9 and A-F
// count as digit zero; type and checksum characters give nothing. One character is taken
// every clock cycle: a character is held in the input register, is decoded against the
// record state, and its entry is loaded into the output register. The chain only stalls
// when an entry is due while the output register still holds one that has not been taken.
module intel_hex_record_parser_top #(
	parameter int RING_DEPTH = 32
) (
	input logic          clk,
	input logic          arst_n,
	ihex_char_if.sink    chars,
	ihex_entry_if.source entries
);

	logic             res_valid;
	logic             can_take;
	ihex_pkg::entry_t res;
	ihex_pkg::entry_t out_data;

	ihex_track #(
		.RING_DEPTH(RING_DEPTH)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chars.valid),
		.in_char   (chars.ascii_char),
		.in_ready  (chars.ready),
		.can_take  (can_take),
		.res_valid (res_valid),
		.res       (res)
	);

	ihex_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.can_take  (can_take),
		.out_valid (entries.valid),
		.out_ready (entries.ready),
		.out_data  (out_data)
	);

	assign entries.entry_kind  = out_data.entry_kind;
	assign entries.entry_value = out_data.entry_value;
	assign entries.slot        = out_data.slot;
	assign entries.words_total = out_data.words_total;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH = 32;

	typedef struct {
		logic [7:0] ch;
		bit         wait_drain;
	} char_item_t;

	logic clk;
	logic arst_n;

	ihex_char_if  char_bus ();
	ihex_entry_if entry_bus ();

	intel_hex_record_parser_top #(
		.RING_DEPTH(RING_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (char_bus),
		.entries (entry_bus)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// record tracking state
	logic [9:0]  rec_pos    = '0;
	logic [9:0]  rec_len    = '0;
	logic [15:0] acc_lo     = '0;
	logic [7:0]  acc_hi     = '0;
	int unsigned ring_slot  = 0;
	logic [15:0] word_tally = '0;

	ihex_pkg::entry_t pending_entries[$];
	char_item_t       char_backlog[$];

	int n_total       = 0;
	int n_rand_chars  = 0;
	int n_chars_taken = 0;
	int n_due         = 0;
	int n_seen        = 0;
	int n_bad         = 0;

	int tx_idle;
	int rx_idle;
	bit tx_burst;
	bit rx_burst;
	bit holding;
	bit hold_done;
	int hold_left;

	function automatic logic [3:0] digit_value(input logic [7:0] ch);
		if (ch >= "0" && ch <= "9") begin
			return ch[3:0];
		end
		if (ch >= "A" && ch <= "F") begin
			return ch[3:0] + 4'd9;
		end
		return 4'h0;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return 8'h30 + {4'h0, nib};
		end
		return 8'h37 + {4'h0, nib};
	endfunction

	function automatic int idle_len(input bit burst);
		int r;
		if (burst) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic log_entry(input logic [1:0] kind, input logic [15:0] value);
		ihex_pkg::entry_t e;
		e.entry_kind  = kind;
		e.entry_value = value;
		e.slot        = 5'(ring_slot);
		e.words_total = word_tally;
		pending_entries.push_back(e);
		ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
	endtask

	task automatic parse_char(input logic [7:0] ch, output int made);
		logic [3:0] d;
		made = 0;
		d = digit_value(ch);
		if (ch == ihex_pkg::COLON_CHAR) begin
			rec_pos = '0;
		end
		case (rec_pos)
			10'd1: acc_lo = {8'h00, d, 4'h0};
			10'd2: begin
				acc_lo  = acc_lo + {12'h000, d};
				rec_len = ihex_pkg::HEADER_CHARS + {acc_lo[8:0], 1'b0};
				log_entry(ihex_pkg::KIND_COUNT, acc_lo);
				made = 1;
			end
			10'd3: acc_lo = {8'h00, d, 4'h0};
			10'd4: acc_lo = {acc_lo[7:0] + {4'h0, d}, 8'h00};
			10'd5: acc_lo = acc_lo + {8'h00, d, 4'h0};
			10'd6: begin
				acc_lo = acc_lo + {12'h000, d};
				log_entry(ihex_pkg::KIND_ADDR, acc_lo);
				made = 1;
			end
			default: ;
		endcase
		if (rec_pos > 10'd8 && rec_pos < rec_len) begin
			case (rec_pos[1:0])
				2'd1: acc_lo = {8'h00, d, 4'h0};
				2'd2: acc_lo = acc_lo + {12'h000, d};
				2'd3: acc_hi = {d, 4'h0};
				default: begin
					acc_hi     = acc_hi + {4'h0, d};
					acc_lo     = acc_lo + {acc_hi, 8'h00};
					word_tally = word_tally + 16'd1;
					log_entry(ihex_pkg::KIND_WORD, acc_lo);
					made = 1;
				end
			endcase
		end
		if (rec_pos < ihex_pkg::POS_MAX) begin
			rec_pos = rec_pos + 10'd1;
		end
	endtask

	task automatic put(input logic [7:0] ch, input bit wait_drain);
		char_item_t it;
		it.ch         = ch;
		it.wait_drain = wait_drain;
		char_backlog.push_back(it);
		n_total++;
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++) begin
			put(s[i], 1'b0);
		end
	endtask

	task automatic add_hex(ref logic [7:0] line[$], input logic [7:0] b);
		line.push_back(hex_digit(b[7:4]));
		line.push_back(hex_digit(b[3:0]));
	endtask

	// well-formed record with random content, sometimes with junk or broken
	task automatic add_record(input int nb, input bit wait_drain);
		logic [7:0]  line[$];
		logic [15:0] addr;
		logic [7:0]  rtype;
		logic [7:0]  sum;
		logic [7:0]  b;
		int          sel;
		int          cut;
		sel   = $urandom_range(0, 19);
		addr  = 16'($urandom);
		rtype = 8'($urandom_range(0, 5));
		if (sel == 0) begin
			repeat ($urandom_range(1, 5)) line.push_back(8'($urandom_range(0, 255)));
		end
		line.push_back(ihex_pkg::COLON_CHAR);
		add_hex(line, nb[7:0]);
		add_hex(line, addr[15:8]);
		add_hex(line, addr[7:0]);
		add_hex(line, rtype);
		sum = nb[7:0] + addr[15:8] + addr[7:0] + rtype;
		for (int i = 0; i < nb; i++) begin
			b   = 8'($urandom_range(0, 255));
			sum = sum + b;
			add_hex(line, b);
		end
		add_hex(line, 8'h00 - sum);
		if (sel == 1) begin
			cut = $urandom_range(1, line.size() - 1);
			while (line.size() > cut) begin
				void'(line.pop_back());
			end
		end else if (sel == 2) begin
			line[$urandom_range(1, line.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (sel >= 15) begin
			line.push_back(8'h0D);
			line.push_back(8'h0A);
		end
		foreach (line[i]) begin
			put(line[i], wait_drain && i == 0);
		end
		n_rand_chars += line.size();
	endtask

	// character sender
	always @(posedge clk or negedge arst_n) begin : char_driver
		char_item_t nxt;
		int         made;
		int         idle;
		bit         free;
		if (!arst_n) begin
			char_bus.valid      <= 1'b0;
			char_bus.ascii_char <= 8'h00;
			tx_idle             <= 0;
			tx_burst            <= 1'b0;
		end else begin
			made = 0;
			idle = tx_idle;
			free = !char_bus.valid;
			if (char_bus.valid && char_bus.ready) begin
				parse_char(char_bus.ascii_char, made);
				n_chars_taken <= n_chars_taken + 1;
				free = 1'b1;
				idle = holding ? 0 : idle_len(tx_burst);
			end
			if (free) begin
				if (idle != 0) begin
					idle--;
					char_bus.valid <= 1'b0;
				end else if (char_backlog.size() != 0 &&
					(!char_backlog[0].wait_drain || n_due + made == n_seen)) begin
					nxt = char_backlog.pop_front();
					char_bus.ascii_char <= nxt.ch;
					char_bus.valid      <= 1'b1;
				end else begin
					char_bus.valid <= 1'b0;
				end
			end
			tx_idle <= idle;
			n_due   <= n_due + made;
			if ($urandom_range(0, 149) == 0) begin
				tx_burst <= !tx_burst;
			end
		end
	end

	// long receiver hold-off while records are still streaming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding   <= 1'b0;
			hold_done <= 1'b0;
			hold_left <= 0;
		end else if (holding) begin
			if (hold_left == 0) begin
				holding   <= 1'b0;
				hold_done <= 1'b1;
			end else begin
				hold_left <= hold_left - 1;
			end
		end else if (!hold_done && n_chars_taken >= 100) begin
			holding   <= 1'b1;
			hold_left <= 200;
		end
	end

	// entry receiver and checker
	always @(posedge clk or negedge arst_n) begin : entry_monitor
		ihex_pkg::entry_t got;
		ihex_pkg::entry_t want;
		int               g;
		if (!arst_n) begin
			entry_bus.ready <= 1'b0;
			rx_idle         <= 0;
			rx_burst        <= 1'b0;
		end else begin
			if (entry_bus.valid && entry_bus.ready) begin
				got = {entry_bus.entry_kind, entry_bus.entry_value, entry_bus.slot,
					entry_bus.words_total};
				if (pending_entries.size() == 0) begin
					n_bad++;
					if (n_bad <= 10) begin
						$display("unexpected entry: kind %0d value %h slot %0d total %0d",
							got.entry_kind, got.entry_value, got.slot, got.words_total);
					end
				end else begin
					want = pending_entries.pop_front();
					n_seen <= n_seen + 1;
					if (got !== want) begin
						n_bad++;
						if (n_bad <= 10) begin
							$display("entry mismatch: exp kind %0d value %h slot %0d total %0d",
								want.entry_kind, want.entry_value, want.slot, want.words_total);
							$display("                got kind %0d value %h slot %0d total %0d",
								got.entry_kind, got.entry_value, got.slot, got.words_total);
						end
					end
				end
			end
			if (rx_idle != 0) begin
				rx_idle         <= rx_idle - 1;
				entry_bus.ready <= 1'b0;
			end else if (holding) begin
				entry_bus.ready <= 1'b0;
			end else begin
				g = idle_len(rx_burst);
				if (g == 0) begin
					entry_bus.ready <= 1'b1;
				end else begin
					entry_bus.ready <= 1'b0;
					rx_idle         <= g - 1;
				end
			end
			if ($urandom_range(0, 149) == 0) begin
				rx_burst <= !rx_burst;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("intel_hex_record_parser_top test failed");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] c;
		int         r;
		int         nb;
		arst_n = 1'b0;

		// characters before any colon, then header-only and one-word records
		put(8'hFF, 1'b0);
		put_str("12");
		put_str(":00FFFF01");
		put(8'h00, 1'b0);
		put_str(":02A0@9009/FEGa");

		add_record(0, 1'b1);
		while (n_rand_chars < 200) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				nb = $urandom_range(0, 6);
			end else if (r < 97) begin
				nb = $urandom_range(7, 32);
			end else begin
				nb = $urandom_range(33, 254);
			end
			add_record(nb, $urandom_range(0, 14) == 0);
		end

		// long run with no colon, past position saturation
		repeat (1030) begin
			c = 8'($urandom_range(0, 255));
			if (c == ihex_pkg::COLON_CHAR) begin
				c = 8'h2E;
			end
			put(c, 1'b0);
		end
		add_record(3, 1'b0);
		add_record(2, 1'b1);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (n_chars_taken != n_total) @(posedge clk);
		while (n_seen != n_due) @(posedge clk);
		repeat (20) @(posedge clk);

		if (n_bad == 0 && pending_entries.size() == 0) begin
			$display("intel_hex_record_parser_top test passed");
		end else begin
			$display("intel_hex_record_parser_top test failed");
		end
		$finish;
	end

endmodule
